// ===== src/quaternion_multiply_rotate_core_assert.svh =====
// Assertion macros shared by the quaternion multiply/rotate core.
`ifndef QUATERNION_MULTIPLY_ROTATE_CORE_ASSERT_SVH
`define QUATERNION_MULTIPLY_ROTATE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define QMR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qmr same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define QMR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qmr next-cycle check failed");

`endif

// ===== src/qmr_pkg.sv =====
`timescale 1ns / 1ps

package qmr_pkg;

   // Operation codes carried in the op field.
   localparam logic OP_PRODUCT = 1'b0;
   localparam logic OP_ROTATE  = 1'b1;

   // Sign patterns of the four terms of each Hamilton product component.
   // Bit i set means term i is subtracted.
   localparam logic [3:0] NEG_W = 4'b1110;
   localparam logic [3:0] NEG_X = 4'b0100;
   localparam logic [3:0] NEG_Y = 4'b1000;
   localparam logic [3:0] NEG_Z = 4'b0010;

   // A quaternion in Q16.16, one 32-bit word per component.
   typedef struct packed {
      logic signed [31:0] z;
      logic signed [31:0] y;
      logic signed [31:0] x;
      logic signed [31:0] w;
   } word_quat_type;

   // A multiplier operand quaternion; one extra bit holds a negated minimum.
   typedef struct packed {
      logic signed [32:0] z;
      logic signed [32:0] y;
      logic signed [32:0] x;
      logic signed [32:0] w;
   } opnd_quat_type;

   // Status that leaves a product unit with its result.
   typedef struct packed {
      logic       valid;
      logic [3:0] ovf;
   } unit_stat_type;

   // Rounded and saturated component.
   typedef struct packed {
      logic signed [31:0] val;
      logic               ovf;
   } rsat_type;

   // Exact signed sum of four products, each optionally negated.
   function automatic logic signed [67:0] sum4(input logic signed [65:0] t0,
                                               input logic signed [65:0] t1,
                                               input logic signed [65:0] t2,
                                               input logic signed [65:0] t3,
                                               input logic [3:0] neg);
      logic signed [65:0] t [4];
      logic signed [67:0] acc;
      logic signed [67:0] ext;
      t[0] = t0;
      t[1] = t1;
      t[2] = t2;
      t[3] = t3;
      acc = '0;
      for (int i = 0; i < 4; i++) begin
         ext = {{2{t[i][65]}}, t[i]};
         if (neg[i]) begin
            acc = acc - ext;
         end else begin
            acc = acc + ext;
         end
      end
      return acc;
   endfunction

   // Round a Q32.32 sum to Q16.16 (half up) and clamp to 32 bits.
   function automatic rsat_type round_sat(input logic signed [67:0] s);
      logic signed [67:0] rnd;
      logic signed [51:0] q;
      rsat_type           res;
      rnd = s + 68'sd32768;
      q = $signed(rnd[67:16]);
      if (q > 52'sd2147483647) begin
         res.val = 32'sh7FFFFFFF;
         res.ovf = 1'b1;
      end else if (q < -52'sd2147483648) begin
         res.val = 32'sh80000000;
         res.ovf = 1'b1;
      end else begin
         res.val = q[31:0];
         res.ovf = 1'b0;
      end
      return res;
   endfunction

endpackage

// ===== src/qmr_hamilton.sv =====
`timescale 1ns / 1ps

// Three-stage Hamilton product: multiply, sum, then round and saturate.
module qmr_hamilton
   import qmr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  opnd_quat_type a_in,
   input  opnd_quat_type b_in,
   output word_quat_type r_out,
   output unit_stat_type stat_out
);

   logic signed [32:0] av [4];
   logic signed [32:0] bv [4];

   logic signed [65:0] prod_in [16];
   logic signed [65:0] prod_ff [16];
   logic signed [67:0] sum_in  [4];
   logic signed [67:0] sum_ff  [4];
   rsat_type           rs      [4];
   word_quat_type      res_in;
   word_quat_type      res_ff;
   logic [3:0]         ovf_in;
   logic [3:0]         ovf_ff;
   logic               s1_valid_ff;
   logic               s2_valid_ff;
   logic               s3_valid_ff;

   assign av[0] = a_in.w;
   assign av[1] = a_in.x;
   assign av[2] = a_in.y;
   assign av[3] = a_in.z;
   assign bv[0] = b_in.w;
   assign bv[1] = b_in.x;
   assign bv[2] = b_in.y;
   assign bv[3] = b_in.z;

   // Stage 1: all sixteen component products, indexed a*4+b.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            prod_in[i*4+j] = av[i] * bv[j];
         end
      end
   end

   // Stage 2: exact sums with the Hamilton sign pattern.
   always_comb begin
      sum_in[0] = sum4(prod_ff[0],  prod_ff[5],  prod_ff[10], prod_ff[15], NEG_W);
      sum_in[1] = sum4(prod_ff[4],  prod_ff[1],  prod_ff[14], prod_ff[11], NEG_X);
      sum_in[2] = sum4(prod_ff[8],  prod_ff[13], prod_ff[2],  prod_ff[7],  NEG_Y);
      sum_in[3] = sum4(prod_ff[12], prod_ff[9],  prod_ff[6],  prod_ff[3],  NEG_Z);
   end

   // Stage 3: round to Q16.16 and saturate each component.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         rs[i] = round_sat(sum_ff[i]);
         ovf_in[i] = rs[i].ovf;
      end
      res_in.w = rs[0].val;
      res_in.x = rs[1].val;
      res_in.y = rs[2].val;
      res_in.z = rs[3].val;
   end

   // Datapath registers move whenever the pipeline advances.
   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         res_ff  <= res_in;
         ovf_ff  <= ovf_in;
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   assign r_out          = res_ff;
   assign stat_out.valid = s3_valid_ff;
   assign stat_out.ovf   = ovf_ff;

endmodule

// ===== src/quaternion_multiply_rotate_core.sv =====
`timescale 1ns / 1ps
`include "quaternion_multiply_rotate_core_assert.svh"

// Quaternion multiply / rotate core, signed Q16.16 throughout.
// Input channel (req_): one transfer carries quaternions a and b in tdata
// and the op bit in tuser. Op 0 returns the Hamilton product a*b; op 1
// rotates the point (b_x, b_y, b_z) by a and returns q*(0,p)*conj(q) with
// the scalar forced to zero. Every component is rounded half up and
// saturated; any saturation raises the overflow flag in rsp_tuser.
// Result channel (rsp_): one transfer per input transfer, in order.
// Each transfer passes through two chained three-stage product units
// (multiply, sum, round) and then an output register.
// Throughput is one item per cycle; the whole pipeline moves in lockstep
// whenever the output register is empty or being taken.
// When the receiver stalls, the output register holds its result and every
// stage freezes, so req_tready drops in the same cycle; nothing is lost.
// Reset clears all valid bits; no state is kept between items.
module quaternion_multiply_rotate_core
   import qmr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z (32 bits each, lowest first)
   input  logic [255:0] req_tdata,
   // op
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // r_w, r_x, r_y, r_z (32 bits each, lowest first)
   output logic [127:0] rsp_tdata,
   // overflow
   output logic         rsp_tuser
);

   logic          adv;
   opnd_quat_type u1_a;
   opnd_quat_type u1_b;
   word_quat_type in_a;
   word_quat_type t_res;
   unit_stat_type t_stat;
   opnd_quat_type u2_a;
   opnd_quat_type u2_b;
   word_quat_type r2_res;
   unit_stat_type r2_stat;

   word_quat_type a_dly_in    [3];
   word_quat_type a_dly_ff    [3];
   logic          op_dly_in   [6];
   logic          op_dly_ff   [6];
   word_quat_type r1_dly_in   [3];
   word_quat_type r1_dly_ff   [3];
   logic          ovf1_dly_in [3];
   logic          ovf1_dly_ff [3];

   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   word_quat_type rsp_data_ff;
   word_quat_type rsp_data_in;
   logic          rsp_ovf_ff;
   logic          rsp_ovf_in;
   logic          rsp_op_ff;
   logic          rsp_op_in;
   logic          rsp_is_rotate;

   // The pipeline moves when the output register is free or being taken.
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Unpack the input transfer.
   assign in_a.w = req_tdata[31:0];
   assign in_a.x = req_tdata[63:32];
   assign in_a.y = req_tdata[95:64];
   assign in_a.z = req_tdata[127:96];

   // First product operands; for a rotation b is the pure quaternion (0,p).
   always_comb begin
      u1_a.w = {in_a.w[31], in_a.w};
      u1_a.x = {in_a.x[31], in_a.x};
      u1_a.y = {in_a.y[31], in_a.y};
      u1_a.z = {in_a.z[31], in_a.z};
      u1_b.w = (req_tuser == OP_ROTATE) ? 33'sd0 : {req_tdata[159], req_tdata[159:128]};
      u1_b.x = {req_tdata[191], req_tdata[191:160]};
      u1_b.y = {req_tdata[223], req_tdata[223:192]};
      u1_b.z = {req_tdata[255], req_tdata[255:224]};
   end

   qmr_hamilton u_first (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_tvalid),
      .a_in     (u1_a),
      .b_in     (u1_b),
      .r_out    (t_res),
      .stat_out (t_stat)
   );

   // Second product: t * conj(a), the conjugate formed exactly in 33 bits.
   always_comb begin
      u2_a.w = {t_res.w[31], t_res.w};
      u2_a.x = {t_res.x[31], t_res.x};
      u2_a.y = {t_res.y[31], t_res.y};
      u2_a.z = {t_res.z[31], t_res.z};
      u2_b.w = {a_dly_ff[2].w[31], a_dly_ff[2].w};
      u2_b.x = 33'sd0 - {a_dly_ff[2].x[31], a_dly_ff[2].x};
      u2_b.y = 33'sd0 - {a_dly_ff[2].y[31], a_dly_ff[2].y};
      u2_b.z = 33'sd0 - {a_dly_ff[2].z[31], a_dly_ff[2].z};
   end

   qmr_hamilton u_second (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (t_stat.valid),
      .a_in     (u2_a),
      .b_in     (u2_b),
      .r_out    (r2_res),
      .stat_out (r2_stat)
   );

   // Side delay lines that keep a, op and the first result aligned.
   always_comb begin
      a_dly_in[0]    = in_a;
      op_dly_in[0]   = req_tuser;
      r1_dly_in[0]   = t_res;
      ovf1_dly_in[0] = |t_stat.ovf;
      for (int i = 1; i < 3; i++) begin
         a_dly_in[i]    = a_dly_ff[i-1];
         r1_dly_in[i]   = r1_dly_ff[i-1];
         ovf1_dly_in[i] = ovf1_dly_ff[i-1];
      end
      for (int i = 1; i < 6; i++) begin
         op_dly_in[i] = op_dly_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_dly_ff    <= a_dly_in;
         op_dly_ff   <= op_dly_in;
         r1_dly_ff   <= r1_dly_in;
         ovf1_dly_ff <= ovf1_dly_in;
      end
   end

   // Select the result of the operation and merge the overflow flags.
   always_comb begin
      rsp_valid_in = r2_stat.valid;
      rsp_op_in    = op_dly_ff[5];
      if (op_dly_ff[5] == OP_ROTATE) begin
         rsp_data_in.w = 32'sd0;
         rsp_data_in.x = r2_res.x;
         rsp_data_in.y = r2_res.y;
         rsp_data_in.z = r2_res.z;
         rsp_ovf_in    = ovf1_dly_ff[2] | (|r2_stat.ovf[3:1]);
      end else begin
         rsp_data_in = r1_dly_ff[2];
         rsp_ovf_in  = ovf1_dly_ff[2];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_ovf_ff  <= rsp_ovf_in;
         rsp_op_ff   <= rsp_op_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   // A valid rotation result sits in the output register.
   assign rsp_is_rotate = rsp_tvalid && (rsp_op_ff == OP_ROTATE);

   // A rotation result always carries a zero scalar.
   `QMR_ASSERT_IMPLY(a_rot_scalar_zero, clock, reset, rsp_is_rotate, rsp_tdata[31:0] == 32'd0)
   // A stalled result holds off new input in the same cycle.
   `QMR_ASSERT_IMPLY(a_stall_blocks_input, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   // A finished item reaches the output register on the next advance.
   `QMR_ASSERT_NEXT(a_result_lands, clock, reset, r2_stat.valid && adv, rsp_tvalid)

endmodule
